>>> sv/hcb_pkg.sv
// hcb_pkg: shared types, constants and mod-26 helpers for the hill cipher block
// no dependencies; imported by every other file of the block

package hcb_pkg;

    localparam int MODULUS       = 26;
    localparam int PAD_LETTER    = 23;
    localparam int MAX_ORDER_DEF = 3;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_KEY_ROW0     = 3'd0;
    localparam logic [2:0] REG_KEY_ROW1     = 3'd1;
    localparam logic [2:0] REG_KEY_ROW2     = 3'd2;
    localparam logic [2:0] REG_BLOCK_SIZE   = 3'd3;
    localparam logic [2:0] REG_DECRYPT_MODE = 3'd4;

    typedef logic [4:0] letter_t;

    typedef struct packed {
        logic [14:0] key_row0;
        logic [14:0] key_row1;
        logic [14:0] key_row2;
        logic [1:0]  block_size;
        logic        decrypt_mode;
    } cfg_t;

    // one request to the shared multiply-accumulate unit
    typedef struct packed {
        letter_t x;
        letter_t y;
        letter_t acc;
    } mac_op_t;

    function automatic letter_t mod26_letter(letter_t v);
        return (v >= 5'(MODULUS)) ? v - 5'(MODULUS) : v;
    endfunction

    function automatic letter_t neg26(letter_t v);
        return (v == 5'd0) ? 5'd0 : 5'(MODULUS) - v;
    endfunction

    // x below 1024: reciprocal estimate is at most one low, one correction
    function automatic letter_t mod26_sum(logic [9:0] x);
        logic [18:0] prod;
        logic [5:0]  q;
        logic [9:0]  r;
        prod = 19'(x) * 19'd315;
        q    = prod[18:13];
        r    = x - 10'(q) * 10'(MODULUS);
        if (r >= 10'(MODULUS))
        begin
            r = r - 10'(MODULUS);
        end
        return r[4:0];
    endfunction

    function automatic letter_t key_letter(logic [14:0] row, logic [1:0] c);
        letter_t raw;
        raw = row[5*c +: 5];
        return mod26_letter(raw);
    endfunction

    function automatic letter_t inv_mod26(letter_t d);
        letter_t r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/hcb_in_if.sv
// hcb_in_if: letter channel into the hill cipher block (valid, ready, payload)
// depends on hcb_pkg for the letter type

interface hcb_in_if import hcb_pkg::*; ();
    logic    valid;
    logic    ready;
    letter_t letter;
    logic    end_of_text;

    modport source (output valid, output letter, output end_of_text, input ready);
    modport sink   (input valid, input letter, input end_of_text, output ready);
endinterface

>>> sv/hcb_out_if.sv
// hcb_out_if: result channel out of the hill cipher block (valid, ready, payload)
// depends on hcb_pkg for the letter type

interface hcb_out_if import hcb_pkg::*; ();
    logic    valid;
    logic    ready;
    letter_t out_letter;
    logic    block_last;
    logic    key_error;

    modport source (output valid, output out_letter, output block_last, output key_error,
                    input ready);
    modport sink   (input valid, input out_letter, input block_last, input key_error,
                    output ready);
endinterface

>>> sv/hill_cipher_block_core.sv
// hill_cipher_block_core: hill cipher mod 26 with letter and result channels
// depends on hcb_pkg, hcb_in_if, hcb_out_if, hcb_regs, hcb_mac, hcb_seq
//
// letters: one beat per letter (0..25, codes above 25 are reduced mod 26) with
// end_of_text on the last letter of a message. letters are gathered into a
// block of n = 2 or 3 (block_size). a full block, or a partial one padded with
// 'x' at end of text in encrypt mode, is sent on results as n beats, block_last
// on the last. in decrypt mode (order 2 only) a partial block is dropped, and a
// key whose determinant has no inverse mod 26 gives beats with key_error set
// and letter 0.
// timing: all products run through one multiply-accumulate mod 26 unit, one
// step per cycle while the output register is free. an encrypt block starts
// once its last letter is accepted; decrypt puts key inversion in front, and
// a key without inverse instead gives n error beats after the determinant
// step (any key at order 3 gives them with no inversion), one per cycle while
// the output register is free. letters is not ready while a block is being
// worked on.
// a stalled receiver holds the current result in the output register; the
// sequencer waits on it and the next letter is taken once the last beat of a
// block is loaded. reset empties the buffer, the output register and sets the
// key to 0, block_size to 2 and encrypt mode; no clearing pass is needed.

module hill_cipher_block_core
    import hcb_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    hcb_in_if.sink            letters,
    hcb_out_if.source         results
);

    cfg_t    cfg;
    mac_op_t mac_op;
    letter_t mac_res;

    hcb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hcb_mac u_mac (
        .op  (mac_op),
        .res (mac_res)
    );

    hcb_seq #(
        .MAX_ORDER (MAX_ORDER)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .letters (letters),
        .results (results),
        .mac_op  (mac_op),
        .mac_res (mac_res)
    );

endmodule

>>> sv/hcb_regs.sv
// hcb_regs: apb-style configuration registers of the hill cipher block
// depends on hcb_pkg for cfg_t and register indexes

module hcb_regs
    import hcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_KEY_ROW0:     cfg_next.key_row0     = pwdata[14:0];
                REG_KEY_ROW1:     cfg_next.key_row1     = pwdata[14:0];
                REG_KEY_ROW2:     cfg_next.key_row2     = pwdata[14:0];
                REG_BLOCK_SIZE:   cfg_next.block_size   = pwdata[1:0];
                REG_DECRYPT_MODE: cfg_next.decrypt_mode = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY_ROW0:     prdata = DATA_W'(cfg_reg.key_row0);
            REG_KEY_ROW1:     prdata = DATA_W'(cfg_reg.key_row1);
            REG_KEY_ROW2:     prdata = DATA_W'(cfg_reg.key_row2);
            REG_BLOCK_SIZE:   prdata = DATA_W'(cfg_reg.block_size);
            REG_DECRYPT_MODE: prdata = DATA_W'(cfg_reg.decrypt_mode);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_row0     <= '0;
            cfg_reg.key_row1     <= '0;
            cfg_reg.key_row2     <= '0;
            cfg_reg.block_size   <= 2'd2;
            cfg_reg.decrypt_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/hcb_mac.sv
// hcb_mac: shared multiply-accumulate mod 26 unit, res = (acc + x*y) mod 26
// depends on hcb_pkg for mac_op_t and mod26_sum

module hcb_mac
    import hcb_pkg::*;
(
    input  mac_op_t op,
    output letter_t res
);

    logic [9:0] sum;

    // operands are already reduced, so the sum stays below 651
    assign sum = 10'(op.acc) + 10'(op.x) * 10'(op.y);
    assign res = mod26_sum(sum);

endmodule

>>> sv/hcb_seq.sv
// hcb_seq: block buffer, key inversion and matrix product sequencer, output register
// depends on hcb_pkg, hcb_in_if, hcb_out_if; drives the shared hcb_mac unit

module hcb_seq
    import hcb_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    hcb_in_if.sink     letters,
    hcb_out_if.source  results,
    output mac_op_t    mac_op,
    input  letter_t    mac_res
);

    localparam int FW = $clog2(MAX_ORDER + 1);
    localparam int IW = $clog2(MAX_ORDER);

    localparam logic [2:0] PS_AD  = 3'd0;
    localparam logic [2:0] PS_DET = 3'd1;
    localparam logic [2:0] PS_M00 = 3'd2;
    localparam logic [2:0] PS_M11 = 3'd3;
    localparam logic [2:0] PS_M01 = 3'd4;
    localparam logic [2:0] PS_M10 = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_MAC  = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   order_reg, order_next;
    logic [IW-1:0]   col_reg, col_next;
    logic [IW-1:0]   k_reg, k_next;
    logic [2:0]      step_reg, step_next;
    logic            err_reg, err_next;
    logic            out_valid_reg, out_valid_next;

    letter_t         buf_reg [MAX_ORDER];
    letter_t         buf_next [MAX_ORDER];
    letter_t         minv_reg [2][2];
    letter_t         minv_next [2][2];
    letter_t         acc_reg, acc_next;
    letter_t         di_reg, di_next;
    letter_t         out_letter_reg, out_letter_next;
    logic            out_last_reg, out_last_next;
    logic            out_err_reg, out_err_next;

    logic            take;
    logic            out_free;
    logic            out_load;
    logic [2:0]      order_wide;
    logic [FW-1:0]   cur_order;
    logic [FW-1:0]   new_fill;
    logic            emit_full;
    logic            pad;
    letter_t         letter_m;
    letter_t         ka, kb, kc, kd;
    letter_t         coef;
    logic [14:0]     coef_row;
    logic            last_k;
    logic            last_col;

    assign letters.ready  = (state_reg == ST_IDLE);
    assign take           = letters.valid && letters.ready;
    assign out_free       = !out_valid_reg || results.ready;

    assign results.valid      = out_valid_reg;
    assign results.out_letter = out_letter_reg;
    assign results.block_last = out_last_reg;
    assign results.key_error  = out_err_reg;

    // order from block_size, clamped to 2..MAX_ORDER
    always_comb
    begin
        order_wide = (cfg.block_size < 2'd2) ? 3'd2 : {1'b0, cfg.block_size};
        if (order_wide > 3'(MAX_ORDER))
        begin
            order_wide = 3'(MAX_ORDER);
        end
        cur_order = FW'(order_wide);
    end

    assign letter_m  = mod26_letter(letters.letter);
    assign new_fill  = fill_reg + FW'(1);
    assign emit_full = (new_fill >= cur_order);
    assign pad       = !emit_full && letters.end_of_text && !cfg.decrypt_mode;

    assign ka = key_letter(cfg.key_row0, 2'd0);
    assign kb = key_letter(cfg.key_row0, 2'd1);
    assign kc = key_letter(cfg.key_row1, 2'd0);
    assign kd = key_letter(cfg.key_row1, 2'd1);

    always_comb
    begin
        if (2'(k_reg) == 2'd0)
        begin
            coef_row = cfg.key_row0;
        end
        else if (2'(k_reg) == 2'd1)
        begin
            coef_row = cfg.key_row1;
        end
        else
        begin
            coef_row = cfg.key_row2;
        end
        if (cfg.decrypt_mode)
        begin
            coef = minv_reg[k_reg[0]][col_reg[0]];
        end
        else
        begin
            coef = key_letter(coef_row, 2'(col_reg));
        end
    end

    assign last_k   = (FW'(k_reg) + FW'(1) == order_reg);
    assign last_col = (FW'(col_reg) + FW'(1) == order_reg);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        order_next      = order_reg;
        col_next        = col_reg;
        k_next          = k_reg;
        step_next       = step_reg;
        err_next        = err_reg;
        acc_next        = acc_reg;
        di_next         = di_reg;
        buf_next        = buf_reg;
        minv_next       = minv_reg;
        out_load        = 1'b0;
        out_letter_next = out_letter_reg;
        out_last_next   = out_last_reg;
        out_err_next    = out_err_reg;
        mac_op          = '{x: 5'd0, y: 5'd0, acc: 5'd0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    for (int i = 0; i < MAX_ORDER; i++)
                    begin
                        if (FW'(i) == fill_reg)
                        begin
                            buf_next[i] = letter_m;
                        end
                        else if (pad && FW'(i) >= new_fill && FW'(i) < cur_order)
                        begin
                            buf_next[i] = 5'(PAD_LETTER);
                        end
                    end
                    if (emit_full || pad)
                    begin
                        fill_next  = '0;
                        order_next = cur_order;
                        col_next   = '0;
                        k_next     = '0;
                        step_next  = PS_AD;
                        err_next   = 1'b0;
                        if (!cfg.decrypt_mode)
                        begin
                            state_next = ST_MAC;
                        end
                        else if (cur_order != FW'(2))
                        begin
                            err_next   = 1'b1;
                            state_next = ST_SEND;
                        end
                        else
                        begin
                            state_next = ST_PREP;
                        end
                    end
                    else if (letters.end_of_text)
                    begin
                        // decrypt drops the partial block
                        fill_next = '0;
                    end
                    else
                    begin
                        fill_next = new_fill;
                    end
                end
            end

            ST_PREP:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    PS_AD:
                    begin
                        mac_op   = '{x: ka, y: kd, acc: 5'd0};
                        acc_next = mac_res;
                    end
                    PS_DET:
                    begin
                        mac_op  = '{x: neg26(kb), y: kc, acc: acc_reg};
                        di_next = inv_mod26(mac_res);
                        if (inv_mod26(mac_res) == 5'd0)
                        begin
                            err_next   = 1'b1;
                            state_next = ST_SEND;
                        end
                    end
                    PS_M00:
                    begin
                        mac_op          = '{x: kd, y: di_reg, acc: 5'd0};
                        minv_next[0][0] = mac_res;
                    end
                    PS_M11:
                    begin
                        mac_op          = '{x: ka, y: di_reg, acc: 5'd0};
                        minv_next[1][1] = mac_res;
                    end
                    PS_M01:
                    begin
                        mac_op          = '{x: neg26(kb), y: di_reg, acc: 5'd0};
                        minv_next[0][1] = mac_res;
                    end
                    default:
                    begin
                        mac_op          = '{x: neg26(kc), y: di_reg, acc: 5'd0};
                        minv_next[1][0] = mac_res;
                        state_next      = ST_MAC;
                    end
                endcase
            end

            ST_MAC:
            begin
                mac_op   = '{x: buf_reg[k_reg], y: coef,
                             acc: (k_reg == '0) ? 5'd0 : acc_reg};
                acc_next = mac_res;
                if (!last_k)
                begin
                    k_next = k_reg + IW'(1);
                end
                else if (out_free)
                begin
                    // column done and the output slot is free: hand it over now
                    out_load        = 1'b1;
                    out_letter_next = mac_res;
                    out_last_next   = last_col;
                    out_err_next    = 1'b0;
                    k_next          = '0;
                    if (last_col)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next = col_reg + IW'(1);
                    end
                end
                else
                begin
                    state_next = ST_SEND;
                end
            end

            ST_SEND:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_letter_next = err_reg ? 5'd0 : acc_reg;
                    out_last_next   = last_col;
                    out_err_next    = err_reg;
                    k_next          = '0;
                    if (last_col)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + IW'(1);
                        state_next = err_reg ? ST_SEND : ST_MAC;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            step_reg      <= PS_AD;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            col_reg       <= col_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg      <= order_next;
        acc_reg        <= acc_next;
        di_reg         <= di_next;
        buf_reg        <= buf_next;
        minv_reg       <= minv_next;
        out_letter_reg <= out_letter_next;
        out_last_reg   <= out_last_next;
        out_err_reg    <= out_err_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FW'(MAX_ORDER))
        else $error("fill count reached the block order without an emission");

    a_prep_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREP |-> order_reg == FW'(2) && cfg.decrypt_mode)
        else $error("key inversion entered outside order-2 decrypt");

    a_mac_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> FW'(k_reg) < order_reg && FW'(col_reg) < order_reg
                                && !err_reg)
        else $error("product step out of range or taken with a bad key");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_letter_reg == 5'd0)
        else $error("key error beat carries a nonzero letter");

endmodule
